// ----- rtl/core/nap_pkg.sv -----
// ----------------------------------------------------------------------------
// nap_pkg
// Shared types and constants for the negacyclic automorphism permuter.
// ----------------------------------------------------------------------------
package nap_pkg;

  // storage geometry
  localparam int unsigned MaxDegree = 4096;
  localparam int unsigned AddrW     = $clog2(MaxDegree);
  localparam int unsigned CountW    = AddrW + 1;
  localparam int unsigned LgEffW    = $clog2(AddrW + 1);
  localparam int unsigned MinLg     = 2;

  // field widths
  localparam int unsigned LgW      = 4;
  localparam int unsigned CoeffW   = 62;
  localparam int unsigned KW       = 13;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 2;

  // reset values of the configuration registers
  localparam logic [LgW-1:0]    LgReset  = LgW'(10);
  localparam logic [CoeffW-1:0] ModReset = CoeffW'(12289);
  localparam logic [KW-1:0]     KReset   = KW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgLog2Degree = 2'd0,
    CfgModulus    = 2'd1,
    CfgAutoIndex  = 2'd2
  } cfg_idx_e;

  typedef enum logic [0:0] {
    ReqLoad   = 1'b0,
    ReqUnload = 1'b1
  } req_e;

  typedef enum logic [StatusW-1:0] {
    StOk        = 2'd0,
    StFull      = 2'd1,
    StNotLoaded = 2'd2,
    StRange     = 2'd3
  } status_e;

  typedef struct packed {
    req_e              req_type;
    logic [CoeffW-1:0] coeff_in;
  } req_t;

  typedef struct packed {
    logic [CoeffW-1:0]  coeff_out;
    logic               last_out;
    logic [StatusW-1:0] status;
  } res_t;

  // active configuration as seen by the datapath
  typedef struct packed {
    logic [LgEffW-1:0] lg_eff;
    logic [CountW-1:0] degree;
    logic [CoeffW-1:0] modulus;
    logic [KW-1:0]     auto_index;
  } cfg_t;

  // target slot of one load
  typedef struct packed {
    logic [AddrW-1:0]  pos;
    logic [CoeffW-1:0] value;
  } perm_t;

  // memory port commands
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [CoeffW-1:0] wdata;
    logic              re;
    logic [AddrW-1:0]  raddr;
  } mem_cmd_t;

endpackage

// ----- rtl/core/nap_ram.sv -----
// ----------------------------------------------------------------------------
// nap_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/nap_perm.sv -----
// ----------------------------------------------------------------------------
// nap_perm
// Target slot and sign of one load: k*i mod 2N, folded to N, negated mod Q.
// ----------------------------------------------------------------------------
module nap_perm (
  input  nap_pkg::cfg_t                    cfg_i,
  input  logic [nap_pkg::CountW-1:0]       load_count_i,
  input  logic [nap_pkg::CoeffW-1:0]       coeff_i,
  output nap_pkg::perm_t                   perm_o
);
  import nap_pkg::*;

  logic [KW+CountW-1:0] prod_full;
  logic [CountW-1:0]    prod;
  logic [CountW-1:0]    deg_mask;
  logic                 negate;

  // k times index, only the low bits matter for mod 2N
  assign prod_full = {{CountW{1'b0}}, cfg_i.auto_index} * {{KW{1'b0}}, load_count_i};
  assign prod      = prod_full[CountW-1:0];

  // bit log2(N) of the product says the slot wrapped into the negated half
  assign deg_mask = cfg_i.degree - CountW'(1);
  assign negate   = prod[cfg_i.lg_eff];

  assign perm_o.pos   = prod[AddrW-1:0] & deg_mask[AddrW-1:0];
  assign perm_o.value = (negate && (coeff_i != '0)) ? (cfg_i.modulus - coeff_i) : coeff_i;

endmodule

// ----- rtl/core/nap_ctrl.sv -----
// ----------------------------------------------------------------------------
// nap_ctrl
// Configuration registers, frame counters, request decode and result stage.
// ----------------------------------------------------------------------------
module nap_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  nap_pkg::req_t                req_i,
  output logic                         busy_o,
  output logic                         done_o,
  output nap_pkg::res_t                res_o,
  input  logic                         cfg_we_i,
  input  logic [nap_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nap_pkg::CoeffW-1:0]   cfg_data_i,
  output nap_pkg::cfg_t                cfg_o,
  output logic [nap_pkg::CountW-1:0]   load_count_o,
  input  nap_pkg::perm_t               perm_i,
  output nap_pkg::mem_cmd_t            mem_cmd_o,
  input  logic [nap_pkg::CoeffW-1:0]   mem_rdata_i
);
  import nap_pkg::*;

  logic [LgW-1:0]    lg_q;
  logic [CoeffW-1:0] mod_q;
  logic [KW-1:0]     k_q;
  logic [CountW-1:0] load_count_q, load_count_d;
  logic [CountW-1:0] unload_count_q, unload_count_d;
  logic              full_q, full_d;
  logic              done_q;
  logic              unload_q, unload_d;
  logic              last_q, last_d;
  status_e           status_q, status_d;

  logic [LgEffW-1:0] lg_eff;
  logic [CountW-1:0] degree;
  logic              accept;
  logic              cfg_hit;
  logic              load_ok;
  logic              unload_ok;

  // clamp the degree to the supported range
  always_comb begin
    if (int'(lg_q) < int'(MinLg)) begin
      lg_eff = LgEffW'(MinLg);
    end else if (int'(lg_q) > int'(AddrW)) begin
      lg_eff = LgEffW'(AddrW);
    end else begin
      lg_eff = LgEffW'(lg_q);
    end
  end

  assign degree = CountW'(1) << lg_eff;

  assign cfg_o.lg_eff     = lg_eff;
  assign cfg_o.degree     = degree;
  assign cfg_o.modulus    = mod_q;
  assign cfg_o.auto_index = k_q;
  assign load_count_o     = load_count_q;

  // one request per cycle, writes land before any later read
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // register writes to a known index restart the frame
  always_comb begin
    unique case (cfg_idx_i)
      CfgLog2Degree, CfgModulus, CfgAutoIndex: cfg_hit = cfg_we_i;
      default:                                 cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q  <= LgReset;
      mod_q <= ModReset;
      k_q   <= KReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLog2Degree: lg_q  <= cfg_data_i[LgW-1:0];
        CfgModulus:    mod_q <= cfg_data_i;
        CfgAutoIndex:  k_q   <= cfg_data_i[KW-1:0];
        default:       ;
      endcase
    end
  end

  // request decode
  always_comb begin
    load_ok        = 1'b0;
    unload_ok      = 1'b0;
    load_count_d   = load_count_q;
    unload_count_d = unload_count_q;
    full_d         = full_q;
    unload_d       = 1'b0;
    last_d         = 1'b0;
    status_d       = StOk;
    if (accept) begin
      unique case (req_i.req_type)
        ReqLoad: begin
          priority if (full_q || (load_count_q >= degree)) begin
            status_d = StFull;
          end else if (req_i.coeff_in >= mod_q) begin
            status_d = StRange;
          end else begin
            load_ok      = 1'b1;
            load_count_d = load_count_q + CountW'(1);
            if (load_count_d >= degree) begin
              full_d         = 1'b1;
              unload_count_d = '0;
            end
          end
        end
        ReqUnload: begin
          if (!full_q || (unload_count_q >= degree)) begin
            status_d = StNotLoaded;
          end else begin
            unload_ok      = 1'b1;
            unload_d       = 1'b1;
            last_d         = (unload_count_q == (degree - CountW'(1)));
            unload_count_d = unload_count_q + CountW'(1);
            if (unload_count_d >= degree) begin
              full_d         = 1'b0;
              load_count_d   = '0;
              unload_count_d = '0;
            end
          end
        end
        default: ;
      endcase
    end
    if (cfg_hit) begin
      load_count_d   = '0;
      unload_count_d = '0;
      full_d         = 1'b0;
    end
  end

  // memory commands
  assign mem_cmd_o.we    = load_ok;
  assign mem_cmd_o.waddr = perm_i.pos;
  assign mem_cmd_o.wdata = perm_i.value;
  assign mem_cmd_o.re    = unload_ok;
  assign mem_cmd_o.raddr = unload_count_q[AddrW-1:0];

  // frame state and result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q   <= '0;
      unload_count_q <= '0;
      full_q         <= 1'b0;
      done_q         <= 1'b0;
      unload_q       <= 1'b0;
      last_q         <= 1'b0;
      status_q       <= StOk;
    end else begin
      load_count_q   <= load_count_d;
      unload_count_q <= unload_count_d;
      full_q         <= full_d;
      done_q         <= accept;
      unload_q       <= unload_d;
      last_q         <= last_d;
      status_q       <= status_d;
    end
  end

  assign done_o          = done_q;
  assign res_o.coeff_out = unload_q ? mem_rdata_i : '0;
  assign res_o.last_out  = last_q;
  assign res_o.status    = status_q;

`ifndef ASSERT_OFF
  // a full buffer holds exactly one frame of loads
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (load_count_q == degree))
    else $error("buffer full without a complete frame");

  // unloading only progresses inside a full frame
  a_unload_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full_q |-> (unload_count_q == '0))
    else $error("unload count moved outside a full frame");

  // every request gets its result in the next cycle
  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request lost its result");

  // the last marker only comes with a good unload
  a_last_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.last_out) |-> (unload_q && (res_o.status == StOk)))
    else $error("last marker on a refused request");
`endif

endmodule

// ----- rtl/core/negacyclic_automorphism_permuter_top.sv -----
// ----------------------------------------------------------------------------
// negacyclic_automorphism_permuter_top
// Applies X -> X^k to a polynomial mod (X^N+1, Q): loads scatter coefficients
// into a coefficient RAM at their permuted slots, unloads read them in order.
//
//   channel   signals                              direction
//   request   start_i, busy_o, req_i               in
//   result    done_o, res_o                        out
//   config    cfg_we_i, cfg_idx_i, cfg_data_i      in
//
// One request per cycle; its result shows on the following cycle for one
// cycle with done_o. A load computes k*i mod 2N with one narrow multiply and
// writes the RAM at that edge; an unload reads the RAM through its registered
// read port. busy_o stays low. Reset clears the counters and restores the
// default registers; the RAM keeps its contents and needs no clearing pass.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module negacyclic_automorphism_permuter_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  nap_pkg::req_t                req_i,
  output logic                         busy_o,
  output logic                         done_o,
  output nap_pkg::res_t                res_o,
  input  logic                         cfg_we_i,
  input  logic [nap_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nap_pkg::CoeffW-1:0]   cfg_data_i
);
  import nap_pkg::*;

  cfg_t              cfg;
  perm_t             perm;
  mem_cmd_t          mem_cmd;
  logic [CountW-1:0] load_count;
  logic [CoeffW-1:0] mem_rdata;

  // control and result stage
  nap_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .res_o        (res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_o        (cfg),
    .load_count_o (load_count),
    .perm_i       (perm),
    .mem_cmd_o    (mem_cmd),
    .mem_rdata_i  (mem_rdata)
  );

  // slot and sign of the current load
  nap_perm u_perm (
    .cfg_i        (cfg),
    .load_count_i (load_count),
    .coeff_i      (req_i.coeff_in),
    .perm_o       (perm)
  );

  // coefficient store
  nap_ram #(
    .Width (CoeffW),
    .Depth (MaxDegree)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_cmd.we),
    .waddr_i (mem_cmd.waddr),
    .wdata_i (mem_cmd.wdata),
    .re_i    (mem_cmd.re),
    .raddr_i (mem_cmd.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- tb/negacyclic_automorphism_permuter_top_tb.sv -----
// ----------------------------------------------------------------------------
// negacyclic_automorphism_permuter_top_tb
// Drives load and unload requests into the permuter and compares every result
// against a cycle-free model of the X -> X^k scatter, including negation,
// refusals, register aborts, even exponents, clamped and capped degrees.
// ----------------------------------------------------------------------------
module negacyclic_automorphism_permuter_top_tb;
  import nap_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgNoReg   = 2'd3;
  localparam logic [CoeffW-1:0]  CoeffMax   = {CoeffW{1'b1}};
  localparam int unsigned        StallLimit = 300;
  localparam int unsigned        RandomGoal = 750;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  req_t              req_i = '0;
  logic              busy_o;
  logic              done_o;
  res_t              res_o;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CoeffW-1:0] cfg_data_i = '0;

  // shadow of the block: registers, counters and coefficient RAM
  logic [LgW-1:0]    shadow_lg = LgReset;
  logic [CoeffW-1:0] shadow_q  = ModReset;
  logic [KW-1:0]     shadow_k  = KReset;
  int unsigned       load_cnt = 0;
  int unsigned       unload_cnt = 0;
  bit                frame_full = 1'b0;
  logic [CoeffW-1:0] shadow_ram [MaxDegree];
  bit                ram_written [MaxDegree];

  res_t        awaited_res [$];
  int unsigned mismatches = 0;
  int unsigned ok_requests = 0;
  int unsigned idle_pct = 26;
  int unsigned stall_cycles = 0;

  negacyclic_automorphism_permuter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock, period 4
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned degree_of(logic [LgW-1:0] lg);
    int unsigned l;
    l = (lg < MinLg) ? MinLg : lg;
    return (l >= 12) ? MaxDegree : (1 << l);
  endfunction

  function automatic logic [CoeffW-1:0] rand62();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[CoeffW-1:0];
  endfunction

  function automatic bit slots_written(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      if (!ram_written[i]) return 1'b0;
    return 1'b1;
  endfunction

  // coefficient below the modulus, biased to the ends of the range
  function automatic logic [CoeffW-1:0] coeff_below_q();
    int unsigned p;
    p = $urandom_range(99);
    if (shadow_q == '0) return '0;
    if (p < 10) return '0;
    if (p < 20) return shadow_q - 1'b1;
    return rand62() % shadow_q;
  endfunction

  // coefficient at or above the modulus
  function automatic logic [CoeffW-1:0] coeff_from_q();
    logic [CoeffW-1:0] span;
    span = CoeffMax - shadow_q;
    if (span == '0 || $urandom_range(3) == 0) return shadow_q;
    return shadow_q + (rand62() % span) + 1'b1;
  endfunction

  // expected result of one accepted request, updates the shadow state
  task automatic permute_request(input req_t r, output res_t e);
    int unsigned       n;
    int unsigned       pos;
    logic [63:0]       prod;
    logic [CoeffW-1:0] v;
    n = degree_of(shadow_lg);
    e = '0;
    if (r.req_type == ReqLoad) begin
      if (frame_full || load_cnt >= n) begin
        e.status = StFull;
      end else if (r.coeff_in >= shadow_q) begin
        e.status = StRange;
      end else begin
        prod = (64'(shadow_k) * 64'(load_cnt)) & 64'(2 * n - 1);
        pos = int'(prod & 64'(n - 1));
        v = r.coeff_in;
        if (prod >= 64'(n) && v != '0) v = shadow_q - v;
        shadow_ram[pos] = v;
        ram_written[pos] = 1'b1;
        load_cnt++;
        if (load_cnt >= n) begin
          frame_full = 1'b1;
          unload_cnt = 0;
        end
      end
    end else begin
      if (!frame_full || unload_cnt >= n) begin
        e.status = StNotLoaded;
      end else begin
        if (!ram_written[unload_cnt]) begin
          $display("%0t stimulus reads unwritten slot %0d", $time, unload_cnt);
          mismatches++;
        end
        e.coeff_out = shadow_ram[unload_cnt];
        e.last_out = (unload_cnt == n - 1);
        unload_cnt++;
        if (unload_cnt >= n) begin
          frame_full = 1'b0;
          load_cnt = 0;
          unload_cnt = 0;
        end
      end
    end
  endtask

  // send one request, called and returning at a falling edge
  task automatic send_request(input req_e kind, input logic [CoeffW-1:0] coeff);
    res_t e;
    if ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 2)) @(negedge clk_i);
    start_i = 1'b1;
    req_i.req_type = kind;
    req_i.coeff_in = coeff;
    do @(posedge clk_i); while (busy_o);
    permute_request(req_i, e);
    if (e.status == StOk) ok_requests++;
    awaited_res.push_back(e);
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (awaited_res.size() != 0) @(negedge clk_i);
  endtask

  // register write while no request is in flight
  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CoeffW-1:0] data);
    wait_drained();
    repeat (2) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgLog2Degree: shadow_lg = data[LgW-1:0];
      CfgModulus:    shadow_q = data;
      CfgAutoIndex:  shadow_k = data[KW-1:0];
      default:       return;
    endcase
    load_cnt = 0;
    unload_cnt = 0;
    frame_full = 1'b0;
  endtask

  // well-formed frame: load until full, then unload until empty
  task automatic stream_frame();
    while (!frame_full) send_request(ReqLoad, coeff_below_q());
    while (frame_full) send_request(ReqUnload, rand62());
  endtask

  // result check and watchdog
  always @(posedge clk_i) begin
    res_t e;
    if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("%0t watchdog: no progress for %0d cycles", $time, stall_cycles);
      $display("FAILURE");
      $finish;
    end
    if (done_o) begin
      if (awaited_res.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, res_o);
        mismatches++;
      end else begin
        e = awaited_res.pop_front();
        if (res_o.coeff_out !== e.coeff_out) begin
          $display("%0t coeff_out mismatch: expected %h actual %h",
                   $time, e.coeff_out, res_o.coeff_out);
          mismatches++;
        end
        if (res_o.last_out !== e.last_out) begin
          $display("%0t last_out mismatch: expected %b actual %b",
                   $time, e.last_out, res_o.last_out);
          mismatches++;
        end
        if (res_o.status !== e.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, e.status, res_o.status);
          mismatches++;
        end
      end
    end
  end

  // reset values, refusals and a small frame under the default k and Q
  task automatic test_reset_values();
    send_request(ReqUnload, '0);
    send_request(ReqLoad, ModReset);
    send_request(ReqLoad, ModReset - 1'b1);
    write_register(CfgLog2Degree, 2);
    send_request(ReqLoad, '0);
    send_request(ReqLoad, ModReset - 1'b1);
    send_request(ReqLoad, 1);
    send_request(ReqLoad, 2);
    send_request(ReqLoad, CoeffMax);
    repeat (4) send_request(ReqUnload, CoeffMax);
    send_request(ReqUnload, '0);
  endtask

  // degree below the minimum, widest modulus, odd k with negation
  task automatic test_degree_clamp();
    write_register(CfgLog2Degree, 0);
    write_register(CfgModulus, CoeffMax);
    write_register(CfgAutoIndex, 3);
    send_request(ReqLoad, CoeffMax - 1'b1);
    send_request(ReqLoad, 1);
    send_request(ReqLoad, '0);
    send_request(ReqLoad, 5);
    repeat (4) send_request(ReqUnload, '0);
    write_register(CfgLog2Degree, 1);
    write_register(CfgAutoIndex, 7);
    send_request(ReqLoad, '0);
    send_request(ReqLoad, 1);
    send_request(ReqLoad, CoeffMax - 1'b1);
    send_request(ReqLoad, CoeffMax);
    send_request(ReqLoad, 9);
    repeat (4) send_request(ReqUnload, '0);
  endtask

  // zero as modulus refuses every load, one as modulus refuses nonzero loads
  task automatic test_small_modulus();
    write_register(CfgModulus, 0);
    send_request(ReqLoad, '0);
    write_register(CfgModulus, 1);
    send_request(ReqLoad, '0);
    send_request(ReqLoad, 1);
    send_request(ReqLoad, CoeffMax);
    write_register(CfgModulus, 2);
    write_register(CfgAutoIndex, 5);
    send_request(ReqLoad, 1);
    send_request(ReqLoad, '0);
    send_request(ReqLoad, 1);
    send_request(ReqLoad, 1);
    repeat (4) send_request(ReqUnload, '0);
  endtask

  // even k: colliding slots, later index wins, old slots survive
  task automatic test_even_index();
    write_register(CfgModulus, 12289);
    write_register(CfgAutoIndex, 2);
    stream_frame();
    write_register(CfgAutoIndex, 0);
    stream_frame();
  endtask

  // a write aborts the frame, an unknown index leaves it alone
  task automatic test_config_abort();
    write_register(CfgAutoIndex, 1);
    send_request(ReqLoad, 11);
    send_request(ReqLoad, 12);
    write_register(CfgNoReg, CoeffMax);
    send_request(ReqLoad, 13);
    send_request(ReqLoad, 14);
    send_request(ReqUnload, '0);
    send_request(ReqUnload, '0);
    write_register(CfgLog2Degree, 2);
    send_request(ReqUnload, '0);
    stream_frame();
  endtask

  // largest and capped degree: partial frames with back-to-back requests,
  // then read back through a small even-k frame that keeps the old slots
  task automatic test_max_degree();
    idle_pct = 0;
    write_register(CfgLog2Degree, 12);
    write_register(CfgModulus, CoeffMax);
    write_register(CfgAutoIndex, 8191);
    repeat (40) send_request(ReqLoad, coeff_below_q());
    write_register(CfgAutoIndex, 4097);
    repeat (40) send_request(ReqLoad, coeff_below_q());
    write_register(CfgLog2Degree, 15);
    repeat (100) send_request(ReqLoad, coeff_below_q());
    idle_pct = 26;
    write_register(CfgLog2Degree, 4);
    write_register(CfgAutoIndex, 0);
    stream_frame();
  endtask

  task automatic random_config();
    int unsigned p;
    int unsigned n;
    logic [KW-1:0] k;
    bit wrote;
    wrote = 1'b0;
    if ($urandom_range(99) < 60) begin
      p = $urandom_range(99);
      if (p < 5) write_register(CfgLog2Degree, CoeffW'($urandom_range(0, 1)));
      else if (p < 90) write_register(CfgLog2Degree, CoeffW'($urandom_range(2, 5)));
      else write_register(CfgLog2Degree, CoeffW'($urandom_range(6, 7)));
      wrote = 1'b1;
    end
    if ($urandom_range(99) < 60) begin
      case ($urandom_range(3))
        0: write_register(CfgModulus, CoeffW'($urandom_range(2, 40)));
        1: write_register(CfgModulus, CoeffW'($urandom_range(2, 16383)));
        2: write_register(CfgModulus, rand62() | 62'd2);
        default: write_register(CfgModulus, CoeffMax);
      endcase
      wrote = 1'b1;
    end
    // a zero modulus refuses every load, so a frame could never fill
    if (shadow_q == '0) begin
      write_register(CfgModulus, CoeffW'($urandom_range(2, 16383)));
      wrote = 1'b1;
    end
    n = degree_of(shadow_lg);
    if (!wrote || $urandom_range(99) < 60) begin
      k = KW'($urandom_range(0, 8191));
      if (!k[0] && !slots_written(n)) k[0] = 1'b1;
      write_register(CfgAutoIndex, k);
    end else if (!shadow_k[0] && !slots_written(n)) begin
      write_register(CfgAutoIndex, shadow_k | 1'b1);
    end
  endtask

  // mostly complete frames with noise, some cut short by a register write
  task automatic random_frame();
    int unsigned n;
    int unsigned cut_at;
    int unsigned steps;
    int unsigned p;
    bit          cut;
    if ($urandom_range(99) < 40) random_config();
    n = degree_of(shadow_lg);
    cut = ($urandom_range(99) < 10);
    cut_at = $urandom_range(0, 2 * n);
    steps = 0;
    while (!frame_full) begin
      if (cut && steps == cut_at) begin
        write_register(CfgIdxW'($urandom_range(0, 3)), '0);
        random_config();
        return;
      end
      p = $urandom_range(99);
      if (p < 6) send_request(ReqUnload, rand62());
      else if (p < 12) send_request(ReqLoad, coeff_from_q());
      else send_request(ReqLoad, coeff_below_q());
      steps++;
    end
    while (frame_full) begin
      if (cut && steps == cut_at) begin
        random_config();
        return;
      end
      if ($urandom_range(99) < 8) send_request(ReqLoad, rand62());
      else send_request(ReqUnload, rand62());
      steps++;
    end
    if ($urandom_range(99) < 30) send_request(ReqUnload, rand62());
    if ($urandom_range(99) < 5) wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned base;
    base = ok_requests;
    write_register(CfgLog2Degree, 3);
    write_register(CfgModulus, 12289);
    write_register(CfgAutoIndex, 5);
    while (ok_requests - base < RandomGoal) random_frame();
  endtask

  initial begin
    for (int i = 0; i < MaxDegree; i++) begin
      shadow_ram[i] = '0;
      ram_written[i] = 1'b0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_degree_clamp();
    test_small_modulus();
    test_even_index();
    test_config_abort();
    test_max_degree();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
